FILE: rtl/slpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants of the status LED pattern generator: mode codes,
// register indexes, register reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package slpg_pkg;

   // elapsed counter width default
   localparam int TIME_BITS_DEFAULT = 16;

   // configuration register file
   localparam int NUM_REGS       = 8;
   localparam int REG_BITS       = 16;
   localparam int CSR_INDEX_BITS = $clog2(NUM_REGS);

   // input item kinds
   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_CHANGE = 1'b1;

   // fault phase counter wraps through this mask
   localparam logic [1:0] FAULT_PHASE_MASK = 2'h3;
   localparam logic [1:0] FAULT_PHASE_GAP  = 2'd1;
   localparam logic [1:0] FAULT_PHASE_PAUSE = 2'd3;

   typedef enum logic [2:0] {
      MODE_HEARTBEAT = 3'd0,
      MODE_ARMED     = 3'd1,
      MODE_CAPTURING = 3'd2,
      MODE_STORED    = 3'd3,
      MODE_FAULT     = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_HB_ON   = 3'd0,
      REG_HB_OFF  = 3'd1,
      REG_ARMED   = 3'd2,
      REG_CAPTURE = 3'd3,
      REG_STORED  = 3'd4,
      REG_FLASH   = 3'd5,
      REG_GAP     = 3'd6,
      REG_PAUSE   = 3'd7
   } reg_index_type;

   // register reset values, milliseconds
   localparam logic [REG_BITS-1:0] HB_ON_RESET   = 16'd50;
   localparam logic [REG_BITS-1:0] HB_OFF_RESET  = 16'd2950;
   localparam logic [REG_BITS-1:0] ARMED_RESET   = 16'd500;
   localparam logic [REG_BITS-1:0] CAPTURE_RESET = 16'd100;
   localparam logic [REG_BITS-1:0] STORED_RESET  = 16'd2000;
   localparam logic [REG_BITS-1:0] FLASH_RESET   = 16'd200;
   localparam logic [REG_BITS-1:0] GAP_RESET     = 16'd200;
   localparam logic [REG_BITS-1:0] PAUSE_RESET   = 16'd1000;

   // timing set seen by the pattern engine
   typedef struct packed {
      logic [REG_BITS-1:0] hb_on;
      logic [REG_BITS-1:0] hb_off;
      logic [REG_BITS-1:0] armed;
      logic [REG_BITS-1:0] capture;
      logic [REG_BITS-1:0] stored;
      logic [REG_BITS-1:0] flash;
      logic [REG_BITS-1:0] gap;
      logic [REG_BITS-1:0] pause;
   } cfg_type;

   // result of one beat
   typedef struct packed {
      logic     led;
      mode_type mode;
   } result_type;

endpackage

FILE: rtl/slpg_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpg_csr
// Timing register file: eight 16-bit millisecond intervals, written through a
// plain write port, reset to their default values.
// ----------------------------------------------------------------------------
module slpg_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [slpg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [slpg_pkg::REG_BITS-1:0]        csr_wdata,
   output slpg_pkg::cfg_type                    cfg
);
   import slpg_pkg::*;

   cfg_type cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hb_on   <= HB_ON_RESET;
         cfg_ff.hb_off  <= HB_OFF_RESET;
         cfg_ff.armed   <= ARMED_RESET;
         cfg_ff.capture <= CAPTURE_RESET;
         cfg_ff.stored  <= STORED_RESET;
         cfg_ff.flash   <= FLASH_RESET;
         cfg_ff.gap     <= GAP_RESET;
         cfg_ff.pause   <= PAUSE_RESET;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_HB_ON:   cfg_ff.hb_on   <= csr_wdata;
            REG_HB_OFF:  cfg_ff.hb_off  <= csr_wdata;
            REG_ARMED:   cfg_ff.armed   <= csr_wdata;
            REG_CAPTURE: cfg_ff.capture <= csr_wdata;
            REG_STORED:  cfg_ff.stored  <= csr_wdata;
            REG_FLASH:   cfg_ff.flash   <= csr_wdata;
            REG_GAP:     cfg_ff.gap     <= csr_wdata;
            REG_PAUSE:   cfg_ff.pause   <= csr_wdata;
            default:     cfg_ff.hb_on   <= cfg_ff.hb_on;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/slpg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpg_core
// Pattern engine: mode, elapsed count, fault phase and LED state, with the
// next-state logic for one tick or mode change per accepted beat.
// ----------------------------------------------------------------------------
module slpg_core #(
   parameter int TIME_BITS = slpg_pkg::TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 req_type,
   input  logic [2:0]           req_new_mode,
   input  slpg_pkg::cfg_type    cfg,
   output slpg_pkg::result_type result_in
);
   import slpg_pkg::*;

   // compare width covers both the counter and the 16-bit intervals
   localparam int CMP_BITS = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   mode_type             mode_ff,    mode_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [1:0]           phase_ff,   phase_in;
   logic                 led_ff,     led_in;

   logic [TIME_BITS-1:0] elapsed_inc;
   logic [REG_BITS-1:0]  interval;
   logic                 match;
   logic [1:0]           phase_next;

   // saturating increment
   assign elapsed_inc = (elapsed_ff == TIME_MAX) ? elapsed_ff
                                                 : elapsed_ff + 1'b1;

   // interval of the current mode and phase
   always_comb begin
      unique case (mode_ff)
         MODE_HEARTBEAT: interval = led_ff ? cfg.hb_on : cfg.hb_off;
         MODE_ARMED:     interval = cfg.armed;
         MODE_CAPTURING: interval = cfg.capture;
         MODE_STORED:    interval = cfg.stored;
         MODE_FAULT: begin
            if (phase_ff == FAULT_PHASE_GAP)
               interval = cfg.gap;
            else if (phase_ff == FAULT_PHASE_PAUSE)
               interval = cfg.pause;
            else
               interval = cfg.flash;
         end
         default:        interval = cfg.hb_off;
      endcase
   end

   assign match      = CMP_BITS'(elapsed_inc) >= CMP_BITS'(interval);
   assign phase_next = (phase_ff + 2'd1) & FAULT_PHASE_MASK;

   // next state for one beat
   always_comb begin
      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      phase_in   = phase_ff;
      led_in     = led_ff;
      if (req_type == REQ_CHANGE) begin
         // codes past fault are ignored
         if (req_new_mode <= 3'(MODE_FAULT)) begin
            mode_in    = mode_type'(req_new_mode);
            elapsed_in = '0;
            phase_in   = '0;
            led_in     = 1'b0;
         end
      end else begin
         elapsed_in = elapsed_inc;
         unique case (mode_ff)
            MODE_STORED: begin
               if (!led_ff) begin
                  led_in     = 1'b1;
                  elapsed_in = '0;
               end else if (match) begin
                  mode_in    = MODE_HEARTBEAT;
                  elapsed_in = '0;
                  phase_in   = '0;
                  led_in     = 1'b0;
               end
            end
            MODE_FAULT: begin
               if (match) begin
                  phase_in   = phase_next;
                  led_in     = !phase_next[0];
                  elapsed_in = '0;
               end
            end
            default: begin
               // heartbeat, armed and capturing toggle on a match
               if (match) begin
                  led_in     = !led_ff;
                  elapsed_in = '0;
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_HEARTBEAT;
         elapsed_ff <= '0;
         phase_ff   <= '0;
         led_ff     <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         phase_ff   <= phase_in;
         led_ff     <= led_in;
      end
   end

   assign result_in.led  = led_in;
   assign result_in.mode = mode_in;

endmodule

FILE: rtl/status_led_pattern_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// The result of an accepted beat is registered in the output register.
// Throughput: one beat per cycle unless the output is stalled; the output
// register frees as the result is taken, so a new beat enters in the same cycle.
// Reset: synchronous, clears mode to heartbeat, count, phase and LED, and
// loads the default timing registers.
// ----------------------------------------------------------------------------
module status_led_pattern_generator #(
   parameter int TIME_BITS = slpg_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [2:0]                          req_new_mode,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_led_level,
   output logic [2:0]                          rsp_current_mode,
   input  logic                                csr_write,
   input  logic [slpg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [slpg_pkg::REG_BITS-1:0]       csr_wdata
);
   import slpg_pkg::*;

   cfg_type    cfg;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // input beat goes in whenever the output register is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   slpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slpg_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_type),
      .req_new_mode (req_new_mode),
      .cfg          (cfg),
      .result_in    (result_in)
   );

   // output register
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_led_level    = result_ff.led;
   assign rsp_current_mode = result_ff.mode;

endmodule
